// File: rtl/core/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared constants, round table and helper functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_ADD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
    ror32 = (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] p);
    sig0 = ror32(p, 7) ^ ror32(p, 18) ^ (p >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] q);
    sig1 = ror32(q, 17) ^ ror32(q, 19) ^ (q >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] a);
    bsig0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] e);
    bsig1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
  endfunction

endpackage

// File: rtl/core/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-serial SHA-256: packs bytes into a 16-word block memory, runs one round
// per cycle against a 16-entry rolling schedule, then emits h0..h7.
// ----------------------------------------------------------------------------
// input: a byte that does not close a block is taken while idle; a block-closing
//   byte stalls the input through load, 64 rounds and add
// final item: padding pass over all 16 words plus compression (load, rounds, add),
//   twice when a length-only block follows; then 8 transfers
// no new byte is taken until the block in flight has been compressed
// reset: synchronous active low, restores the initial hash and zero count
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_message_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha256_pkg::state_t state_r, state_nxt;

  // block memory: one write port, one registered read port
  logic [31:0] blk_mem [16];
  logic        blk_we;
  logic [3:0]  blk_waddr;
  logic [31:0] blk_wdata;
  logic [3:0]  blk_raddr;
  logic [31:0] blk_rdata_r;

  logic [31:0] hash_r [8];
  logic [31:0] wv_r [8];
  logic [31:0] w_r [16];
  logic [60:0] count_r;
  logic [6:0]  rnd_r;
  logic [3:0]  pad_idx_r;
  logic        two_blk_r;
  logic        final_r;
  logic [31:0] acc_r;
  logic [2:0]  oidx_r;
  logic        ovalid_r;

  logic        accept;
  logic [5:0]  pos;
  logic [31:0] byte_word;
  logic [31:0] kw;
  logic [31:0] t1, t2;
  logic [31:0] w_next;
  logic [63:0] bits;
  logic [5:0]  end_pos;
  logic [31:0] pad_word;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != sha256_pkg::ST_IDLE);
  assign pos      = count_r[5:0];
  assign end_pos  = count_r[5:0];
  assign bits     = {count_r, 3'b000};

  // merge byte into partially built word held in acc_r
  always_comb begin
    case (pos[1:0])
      2'd0: byte_word = {in_data_byte, 24'h0};
      2'd1: byte_word = {acc_r[31:24], in_data_byte, 16'h0};
      2'd2: byte_word = {acc_r[31:16], in_data_byte, 8'h0};
      default: byte_word = {acc_r[31:8], in_data_byte};
    endcase
  end

  // padding word for index pad_idx_r given end position
  always_comb begin
    logic [31:0] tmp;
    tmp = 32'h0;
    if (pad_idx_r == 4'd14) begin
      tmp = bits[63:32];
    end else if (pad_idx_r == 4'd15) begin
      tmp = bits[31:0];
    end
    if (!final_r) begin
      if (pad_idx_r < end_pos[5:2]) begin
        tmp = 32'h0;
      end else if (pad_idx_r == end_pos[5:2]) begin
        case (end_pos[1:0])
          2'd0: tmp = {sha256_pkg::PAD_BYTE, 24'h0};
          2'd1: tmp = {acc_r[31:24], sha256_pkg::PAD_BYTE, 16'h0};
          2'd2: tmp = {acc_r[31:16], sha256_pkg::PAD_BYTE, 8'h0};
          default: tmp = {acc_r[31:8], sha256_pkg::PAD_BYTE};
        endcase
      end else if (end_pos >= 6'd56) begin
        tmp = 32'h0;
      end
    end
    pad_word = tmp;
  end

  // round logic
  assign kw     = (rnd_r[6:4] == 3'd0) ? blk_rdata_r : w_next;
  assign t1     = wv_r[7] + sha256_pkg::bsig1(wv_r[4])
                  + ((wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]))
                  + sha256_pkg::ROUND_K[rnd_r[5:0]] + kw;
  assign t2     = sha256_pkg::bsig0(wv_r[0])
                  + ((wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]));
  assign w_next = w_r[0] + sha256_pkg::sig0(w_r[1]) + w_r[9] + sha256_pkg::sig1(w_r[14]);

  always_comb begin
    blk_we    = 1'b0;
    blk_waddr = pos[5:2];
    blk_wdata = byte_word;
    blk_raddr = 4'd0;
    state_nxt = state_r;
    unique case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_byte_present) begin
            blk_we = 1'b1;
            if (pos == 6'd63) begin
              state_nxt = sha256_pkg::ST_LOAD;
            end else if (in_message_end) begin
              state_nxt = sha256_pkg::ST_PAD;
            end
          end else if (in_message_end) begin
            state_nxt = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        // message words ahead of the end word stay as written
        blk_we    = final_r || (pad_idx_r >= end_pos[5:2]);
        blk_waddr = pad_idx_r;
        blk_wdata = pad_word;
        if (pad_idx_r == 4'd15) begin
          state_nxt = sha256_pkg::ST_LOAD;
        end
      end
      sha256_pkg::ST_LOAD: begin
        state_nxt = sha256_pkg::ST_ROUND;
        blk_raddr = 4'd0;
      end
      sha256_pkg::ST_ROUND: begin
        blk_raddr = rnd_r[3:0] + 4'd1;
        if (rnd_r == 7'd63) begin
          state_nxt = sha256_pkg::ST_ADD;
        end
      end
      sha256_pkg::ST_ADD: begin
        if (two_blk_r) begin
          state_nxt = sha256_pkg::ST_PAD;
        end else if (final_r) begin
          state_nxt = sha256_pkg::ST_OUT;
        end else begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end
      sha256_pkg::ST_OUT: begin
        if (out_valid && !out_stall && oidx_r == 3'd7) begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha256_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    blk_rdata_r <= blk_mem[blk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sha256_pkg::ST_IDLE;
      count_r   <= '0;
      rnd_r     <= '0;
      pad_idx_r <= '0;
      two_blk_r <= 1'b0;
      final_r   <= 1'b0;
      oidx_r    <= '0;
      ovalid_r  <= 1'b0;
      acc_r     <= '0;
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= sha256_pkg::INIT_HASH[i];
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        sha256_pkg::ST_IDLE: begin
          if (accept && in_byte_present) begin
            acc_r   <= byte_word;
            count_r <= count_r + 61'd1;
            // an end on a block-closing byte pads a fresh block after this one
            if (pos == 6'd63 && in_message_end) begin
              two_blk_r <= 1'b1;
            end
          end
        end
        sha256_pkg::ST_PAD: begin
          pad_idx_r <= pad_idx_r + 4'd1;
          // first pass decides whether a length-only block follows
          if (pad_idx_r == 4'd15 && !final_r) begin
            final_r   <= 1'b1;
            two_blk_r <= (end_pos >= 6'd56);
          end
        end
        sha256_pkg::ST_LOAD: begin
          rnd_r <= '0;
          for (int i = 0; i < 8; i++) begin
            wv_r[i] <= hash_r[i];
          end
        end
        sha256_pkg::ST_ROUND: begin
          rnd_r <= rnd_r + 7'd1;
          wv_r[7] <= wv_r[6];
          wv_r[6] <= wv_r[5];
          wv_r[5] <= wv_r[4];
          wv_r[4] <= wv_r[3] + t1;
          wv_r[3] <= wv_r[2];
          wv_r[2] <= wv_r[1];
          wv_r[1] <= wv_r[0];
          wv_r[0] <= t1 + t2;
          // rolling schedule window, w_r[15] is the newest word
          for (int i = 0; i < 15; i++) begin
            w_r[i] <= w_r[i + 1];
          end
          w_r[15] <= kw;
        end
        sha256_pkg::ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash_r[i] <= hash_r[i] + wv_r[i];
          end
          pad_idx_r <= 4'd0;
          two_blk_r <= 1'b0;
          if (final_r && !two_blk_r) begin
            oidx_r   <= '0;
            ovalid_r <= 1'b1;
          end
        end
        sha256_pkg::ST_OUT: begin
          if (ovalid_r && !out_stall) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              ovalid_r  <= 1'b0;
              final_r   <= 1'b0;
              count_r   <= '0;
              for (int i = 0; i < 8; i++) begin
                hash_r[i] <= sha256_pkg::INIT_HASH[i];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = ovalid_r;
  assign out_digest_word = hash_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

endmodule
